>>> design/write_batch_record_parser_assert.svh
// Assertion macros used by the write batch parser design file.
`ifndef WRITE_BATCH_RECORD_PARSER_ASSERT_SVH
`define WRITE_BATCH_RECORD_PARSER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define WBRP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("write batch parser check failed");

// Check that cons holds in the cycle after ante.
`define WBRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("write batch parser check failed");

`endif

>>> design/wbrp_pkg.sv
// Package with constants and types for the write batch record parser.
package wbrp_pkg;

   // Batch header layout
   localparam int HEADER_BYTES     = 12;
   localparam int SEQ_BYTES        = 8;
   localparam int VARINT_MAX_BYTES = 5;

   typedef logic [1:0] kind_type;
   typedef logic [2:0] status_type;
   typedef logic       csr_index_type;

   // Result kinds
   localparam kind_type KIND_KEY    = 2'd0;
   localparam kind_type KIND_VALUE  = 2'd1;
   localparam kind_type KIND_RECORD = 2'd2;
   localparam kind_type KIND_BATCH  = 2'd3;

   // Batch status codes
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_TOO_SHORT   = 3'd1;
   localparam status_type ST_BAD_PUT     = 3'd2;
   localparam status_type ST_BAD_DELETE  = 3'd3;
   localparam status_type ST_UNKNOWN_TAG = 3'd4;
   localparam status_type ST_WRONG_COUNT = 3'd5;

   // Register indexes
   localparam csr_index_type CSR_VALUE_TAG    = 1'b0;
   localparam csr_index_type CSR_DELETION_TAG = 1'b1;

endpackage

>>> design/wbrp_if.sv
// Channel interfaces of the write batch record parser.
interface wbrp_req_if import wbrp_pkg::*; ;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       batch_end;

   modport source (output valid, output data_byte, output batch_end, input ready);
   modport sink   (input valid, input data_byte, input batch_end, output ready);
endinterface

interface wbrp_rsp_if import wbrp_pkg::*; ;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  payload_byte;
   logic        record_is_delete;
   logic [63:0] sequence_res;
   status_type  status;
   logic        last;

   modport source (output valid, output kind, output payload_byte, output record_is_delete,
                   output sequence_res, output status, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input record_is_delete,
                   input sequence_res, input status, input last, output ready);
endinterface

interface wbrp_csr_if import wbrp_pkg::*; ;
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [7:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/write_batch_record_parser.sv
// Write batch record parser: streams a length-prefixed batch one byte per transaction,
// emits key/value bytes, record-done and batch-done transactions. Every accepted byte
// updates the parser state and loads up to three results (data byte, record done, batch
// done) into a result register that drains one result per cycle while the receiver is
// ready. The next byte is held off until the last pending result leaves on the single
// result port. Configuration writes are never stalled. No clearing pass is needed after
// reset.
`include "write_batch_record_parser_assert.svh"

module write_batch_record_parser import wbrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   wbrp_req_if.sink    req_port,
   wbrp_rsp_if.source  rsp_port,
   wbrp_csr_if.sink    csr_port
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_TAG    = 3'd1,
      PH_KLEN   = 3'd2,
      PH_KDATA  = 3'd3,
      PH_VLEN   = 3'd4,
      PH_VDATA  = 3'd5
   } phase_type;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [3:0]  header_index_ff, header_index_in;
   logic [63:0] next_sequence_ff, next_sequence_in;
   logic [31:0] expected_count_ff, expected_count_in;
   logic [31:0] records_found_ff, records_found_in;
   logic [31:0] length_acc_ff, length_acc_in;
   logic [2:0]  varint_seen_ff, varint_seen_in;
   logic [31:0] bytes_remaining_ff, bytes_remaining_in;
   logic        current_is_delete_ff, current_is_delete_in;
   logic        error_seen_ff, error_seen_in;

   // Configuration
   logic [7:0]  value_tag_ff, value_tag_in;
   logic [7:0]  deletion_tag_ff, deletion_tag_in;

   // Result register: up to three results in fixed order
   logic        has_data_ff, has_data_in;
   logic        has_rec_ff, has_rec_in;
   logic        has_batch_ff, has_batch_in;
   kind_type    data_kind_ff;
   logic [7:0]  data_byte_ff;
   logic        rec_del_ff;
   logic [63:0] rec_seq_ff;
   status_type  batch_status_ff;

   // Results produced by the current byte
   logic        new_data, new_rec, new_batch;
   kind_type    new_data_kind;
   logic        new_rec_del;
   logic [63:0] new_rec_seq;
   status_type  new_status;

   logic        req_fire, rsp_fire;
   logic        do_rearm, str_done, fail;
   status_type  fail_status;
   logic [5:0]  varint_shift;
   logic [31:0] acc_add, acc_upd;
   logic        rest_data, rest_rec, rest_batch;
   logic        left_data, left_rec, left_batch;

   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_port.valid && rsp_port.ready;

   // Varint accumulation: 7 bits per length byte
   assign varint_shift = {varint_seen_ff, 3'b000} - {3'b000, varint_seen_ff};
   always_comb begin
      acc_add = '0;
      if (varint_seen_ff < 3'(VARINT_MAX_BYTES)) begin
         acc_add = {25'b0, req_port.data_byte[6:0]} << varint_shift;
      end
   end
   assign acc_upd = length_acc_ff | acc_add;

   // Per-byte parser step
   always_comb begin
      phase_in             = phase_ff;
      header_index_in      = header_index_ff;
      next_sequence_in     = next_sequence_ff;
      expected_count_in    = expected_count_ff;
      records_found_in     = records_found_ff;
      length_acc_in        = length_acc_ff;
      varint_seen_in       = varint_seen_ff;
      bytes_remaining_in   = bytes_remaining_ff;
      current_is_delete_in = current_is_delete_ff;
      error_seen_in        = error_seen_ff;
      new_data             = 1'b0;
      new_data_kind        = KIND_KEY;
      new_rec              = 1'b0;
      new_rec_del          = 1'b0;
      new_rec_seq          = next_sequence_ff;
      new_batch            = 1'b0;
      new_status           = ST_OK;
      do_rearm             = 1'b0;
      str_done             = 1'b0;
      fail                 = 1'b0;
      fail_status          = ST_OK;

      if (error_seen_ff) begin
         // Drop bytes until the end of the batch
         do_rearm = req_port.batch_end;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_index_ff < 4'(SEQ_BYTES)) begin
                  next_sequence_in = next_sequence_ff |
                     ({56'b0, req_port.data_byte} << {header_index_ff[2:0], 3'b000});
               end else if (header_index_ff < 4'(HEADER_BYTES)) begin
                  expected_count_in = expected_count_ff |
                     ({24'b0, req_port.data_byte} << {header_index_ff[1:0], 3'b000});
               end
               if (header_index_ff >= 4'(HEADER_BYTES - 1)) begin
                  header_index_in = 4'(HEADER_BYTES);
                  phase_in        = PH_TAG;
               end else begin
                  header_index_in = header_index_ff + 4'd1;
               end
            end
            PH_TAG: begin
               records_found_in = records_found_ff + 32'd1;
               length_acc_in    = '0;
               varint_seen_in   = '0;
               if (req_port.data_byte == value_tag_ff) begin
                  current_is_delete_in = 1'b0;
                  phase_in             = PH_KLEN;
               end else if (req_port.data_byte == deletion_tag_ff) begin
                  current_is_delete_in = 1'b1;
                  phase_in             = PH_KLEN;
               end else begin
                  length_acc_in  = length_acc_ff;
                  varint_seen_in = varint_seen_ff;
                  fail           = 1'b1;
                  fail_status    = ST_UNKNOWN_TAG;
               end
            end
            PH_KLEN, PH_VLEN: begin
               length_acc_in = acc_upd;
               if (req_port.data_byte[7]) begin
                  varint_seen_in = varint_seen_ff + 3'd1;
                  if (varint_seen_ff >= 3'(VARINT_MAX_BYTES - 1)) begin
                     fail        = 1'b1;
                     fail_status = current_is_delete_ff ? ST_BAD_DELETE : ST_BAD_PUT;
                  end
               end else begin
                  bytes_remaining_in = acc_upd;
                  if (acc_upd == 32'd0) begin
                     str_done = 1'b1;
                  end else begin
                     phase_in = (phase_ff == PH_KLEN) ? PH_KDATA : PH_VDATA;
                  end
               end
            end
            PH_KDATA, PH_VDATA: begin
               new_data           = 1'b1;
               new_data_kind      = (phase_ff == PH_KDATA) ? KIND_KEY : KIND_VALUE;
               bytes_remaining_in = bytes_remaining_ff - 32'd1;
               str_done           = (bytes_remaining_ff == 32'd1);
            end
            default: begin
               phase_in = PH_HEADER;
               do_rearm = 1'b1;
            end
         endcase

         // Finish a string: move on to the value or close the record
         if (str_done) begin
            if ((phase_ff == PH_KLEN || phase_ff == PH_KDATA) && !current_is_delete_ff) begin
               phase_in       = PH_VLEN;
               length_acc_in  = '0;
               varint_seen_in = '0;
            end else begin
               new_rec          = 1'b1;
               new_rec_del      = current_is_delete_ff;
               next_sequence_in = next_sequence_ff + 64'd1;
               phase_in         = PH_TAG;
            end
         end

         // Report an error; the end byte rearms at once
         if (fail) begin
            new_batch = 1'b1;
            new_status = fail_status;
            if (req_port.batch_end) begin
               do_rearm = 1'b1;
            end else begin
               error_seen_in = 1'b1;
            end
         end else if (req_port.batch_end) begin
            // Close the batch
            if (phase_in != PH_HEADER) begin
               new_batch = 1'b1;
               if (phase_in == PH_TAG) begin
                  new_status = (records_found_in == expected_count_in) ?
                               ST_OK : ST_WRONG_COUNT;
               end else begin
                  new_status = current_is_delete_in ? ST_BAD_DELETE : ST_BAD_PUT;
               end
               do_rearm = 1'b1;
            end else if (!new_data && !new_rec) begin
               new_batch  = 1'b1;
               new_status = ST_TOO_SHORT;
               do_rearm   = 1'b1;
            end
         end
      end

      if (do_rearm) begin
         phase_in             = PH_HEADER;
         header_index_in      = '0;
         next_sequence_in     = '0;
         expected_count_in    = '0;
         records_found_in     = '0;
         length_acc_in        = '0;
         varint_seen_in       = '0;
         bytes_remaining_in   = '0;
         current_is_delete_in = 1'b0;
         error_seen_in        = 1'b0;
      end
   end

   // Drain: the first pending result leaves on each response transaction
   always_comb begin
      rest_data  = 1'b0;
      rest_rec   = has_rec_ff;
      rest_batch = has_batch_ff;
      if (!has_data_ff) begin
         rest_rec = 1'b0;
         if (!has_rec_ff) begin
            rest_batch = 1'b0;
         end
      end
      left_data  = rsp_fire ? rest_data  : has_data_ff;
      left_rec   = rsp_fire ? rest_rec   : has_rec_ff;
      left_batch = rsp_fire ? rest_batch : has_batch_ff;
      if (req_fire) begin
         has_data_in  = new_data;
         has_rec_in   = new_rec;
         has_batch_in = new_batch;
      end else begin
         has_data_in  = left_data;
         has_rec_in   = left_rec;
         has_batch_in = left_batch;
      end
   end

   assign req_port.ready = !(left_data || left_rec || left_batch);

   // Present the first pending result
   always_comb begin
      rsp_port.valid            = has_data_ff || has_rec_ff || has_batch_ff;
      rsp_port.last             = !(rest_data || rest_rec || rest_batch);
      rsp_port.kind             = KIND_BATCH;
      rsp_port.payload_byte     = '0;
      rsp_port.record_is_delete = 1'b0;
      rsp_port.sequence_res     = '0;
      rsp_port.status           = batch_status_ff;
      priority if (has_data_ff) begin
         rsp_port.kind         = data_kind_ff;
         rsp_port.payload_byte = data_byte_ff;
         rsp_port.status       = ST_OK;
      end else if (has_rec_ff) begin
         rsp_port.kind             = KIND_RECORD;
         rsp_port.record_is_delete = rec_del_ff;
         rsp_port.sequence_res     = rec_seq_ff;
         rsp_port.status           = ST_OK;
      end else begin
         rsp_port.kind = KIND_BATCH;
      end
   end

   // Register writes
   assign csr_port.ready = 1'b1;
   always_comb begin
      value_tag_in    = value_tag_ff;
      deletion_tag_in = deletion_tag_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_VALUE_TAG:    value_tag_in    = csr_port.data;
            CSR_DELETION_TAG: deletion_tag_in = csr_port.data;
            default:          value_tag_in    = value_tag_ff;
         endcase
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_HEADER;
         header_index_ff      <= '0;
         next_sequence_ff     <= '0;
         expected_count_ff    <= '0;
         records_found_ff     <= '0;
         length_acc_ff        <= '0;
         varint_seen_ff       <= '0;
         bytes_remaining_ff   <= '0;
         current_is_delete_ff <= 1'b0;
         error_seen_ff        <= 1'b0;
         value_tag_ff         <= 8'd1;
         deletion_tag_ff      <= 8'd0;
         has_data_ff          <= 1'b0;
         has_rec_ff           <= 1'b0;
         has_batch_ff         <= 1'b0;
      end else begin
         value_tag_ff    <= value_tag_in;
         deletion_tag_ff <= deletion_tag_in;
         has_data_ff     <= has_data_in;
         has_rec_ff      <= has_rec_in;
         has_batch_ff    <= has_batch_in;
         if (req_fire) begin
            phase_ff             <= phase_in;
            header_index_ff      <= header_index_in;
            next_sequence_ff     <= next_sequence_in;
            expected_count_ff    <= expected_count_in;
            records_found_ff     <= records_found_in;
            length_acc_ff        <= length_acc_in;
            varint_seen_ff       <= varint_seen_in;
            bytes_remaining_ff   <= bytes_remaining_in;
            current_is_delete_ff <= current_is_delete_in;
            error_seen_ff        <= error_seen_in;
            data_kind_ff         <= new_data_kind;
            data_byte_ff         <= req_port.data_byte;
            rec_del_ff           <= new_rec_del;
            rec_seq_ff           <= new_rec_seq;
            batch_status_ff      <= new_status;
         end
      end
   end

   // Bytes after an error produce nothing
   `WBRP_ASSERT_NEXT(a_error_drops, clock, reset, req_fire && error_seen_ff, !rsp_port.valid)
   // Every end-of-batch byte leaves the parser waiting for a new header
   `WBRP_ASSERT_NEXT(a_end_rearms, clock, reset, req_fire && req_port.batch_end,
                     phase_ff == PH_HEADER && header_index_ff == 4'd0 && !error_seen_ff)
   // Leaving the header phase means the whole header was taken
   `WBRP_ASSERT_IMPLY(a_header_full, clock, reset, phase_ff != PH_HEADER,
                      header_index_ff == 4'(HEADER_BYTES))

endmodule

>>> test/wbrp_result_checker.sv
// Result checker for the write batch record parser: predicts results and compares them.
`timescale 1ns / 1ps

module wbrp_result_checker import wbrp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  logic [7:0]    req_data_byte,
   input  logic          req_batch_end,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  kind_type      rsp_kind,
   input  logic [7:0]    rsp_payload_byte,
   input  logic          rsp_record_is_delete,
   input  logic [63:0]   rsp_sequence_res,
   input  status_type    rsp_status,
   input  logic          rsp_last,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_data,
   output int            mismatch_count,
   output int            pending_results,
   output int            results_checked
);

   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_TAG,
      PARSE_KEY_LEN,
      PARSE_KEY_DATA,
      PARSE_VALUE_LEN,
      PARSE_VALUE_DATA
   } parse_phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        record_is_delete;
      logic [63:0] sequence_res;
      status_type  status;
      logic        last;
   } parser_result_type;

   parser_result_type expected_results[$];
   parser_result_type byte_results[$];

   // Tag registers as the parser should hold them
   logic [7:0] put_tag;
   logic [7:0] del_tag;

   // Parser state
   parse_phase_type phase;
   logic [3:0]   hdr_index;
   logic [63:0]  seq_next;
   logic [31:0]  count_expected;
   logic [31:0]  count_found;
   logic [31:0]  len_acc;
   logic [2:0]   varint_count;
   logic [31:0]  data_left;
   logic         cur_delete;
   logic         in_error;

   int mismatches;
   int results_seen;

   function automatic void rearm_parser();
      phase          = PARSE_HEADER;
      hdr_index      = '0;
      seq_next       = '0;
      count_expected = '0;
      count_found    = '0;
      len_acc        = '0;
      varint_count   = '0;
      data_left      = '0;
      cur_delete     = 1'b0;
      in_error       = 1'b0;
   endfunction

   function automatic void add_result(kind_type k, logic [7:0] b, logic del,
                                      logic [63:0] seq, status_type st);
      parser_result_type r;
      r.kind             = k;
      r.payload_byte     = b;
      r.record_is_delete = del;
      r.sequence_res     = seq;
      r.status           = st;
      r.last             = 1'b0;
      byte_results.insert(byte_results.size(), r);
   endfunction

   // Report an error; a batch_end byte rearms at once, otherwise drop until batch_end
   function automatic void abort_batch(status_type st, logic end_flag);
      add_result(KIND_BATCH, 8'h00, 1'b0, 64'd0, st);
      if (end_flag) begin
         rearm_parser();
      end else begin
         in_error = 1'b1;
      end
   endfunction

   // Close a key or value string: a put key moves on to the value, else the record is done
   function automatic void finish_string();
      if ((phase == PARSE_KEY_LEN || phase == PARSE_KEY_DATA) && !cur_delete) begin
         phase        = PARSE_VALUE_LEN;
         len_acc      = '0;
         varint_count = '0;
      end else begin
         add_result(KIND_RECORD, 8'h00, cur_delete, seq_next, ST_OK);
         seq_next = seq_next + 64'd1;
         phase    = PARSE_TAG;
      end
   endfunction

   // Advance the parser by one byte and queue the results it causes
   function automatic void predict_byte(logic [7:0] b, logic end_flag);
      int shift;
      byte_results.delete();
      if (in_error) begin
         if (end_flag) begin
            rearm_parser();
         end
         return;
      end

      unique case (phase)
         PARSE_HEADER: begin
            if (hdr_index < SEQ_BYTES) begin
               seq_next[8*hdr_index +: 8] = b;
            end else begin
               count_expected[8*(hdr_index - SEQ_BYTES) +: 8] = b;
            end
            hdr_index = hdr_index + 4'd1;
            if (hdr_index >= HEADER_BYTES) begin
               phase = PARSE_TAG;
            end
         end
         PARSE_TAG: begin
            count_found = count_found + 32'd1;
            if (b == put_tag || b == del_tag) begin
               cur_delete   = (b != put_tag);
               phase        = PARSE_KEY_LEN;
               len_acc      = '0;
               varint_count = '0;
            end else begin
               abort_batch(ST_UNKNOWN_TAG, end_flag);
            end
         end
         PARSE_KEY_LEN, PARSE_VALUE_LEN: begin
            shift = 7 * varint_count;
            if (shift < 32) begin
               len_acc = len_acc | (32'(b[6:0]) << shift);
            end
            if (b[7]) begin
               varint_count = varint_count + 3'd1;
               if (varint_count >= VARINT_MAX_BYTES) begin
                  abort_batch(cur_delete ? ST_BAD_DELETE : ST_BAD_PUT, end_flag);
               end
            end else begin
               data_left = len_acc;
               if (data_left == 0) begin
                  finish_string();
               end else begin
                  phase = (phase == PARSE_KEY_LEN) ? PARSE_KEY_DATA : PARSE_VALUE_DATA;
               end
            end
         end
         PARSE_KEY_DATA, PARSE_VALUE_DATA: begin
            add_result((phase == PARSE_KEY_DATA) ? KIND_KEY : KIND_VALUE, b, 1'b0, 64'd0,
                       ST_OK);
            data_left = data_left - 32'd1;
            if (data_left == 0) begin
               finish_string();
            end
         end
         default: begin
            rearm_parser();
         end
      endcase

      // Close the batch on its last byte
      if (end_flag && !in_error) begin
         if (phase != PARSE_HEADER) begin
            if (phase == PARSE_TAG) begin
               add_result(KIND_BATCH, 8'h00, 1'b0, 64'd0,
                          (count_found == count_expected) ? ST_OK : ST_WRONG_COUNT);
            end else begin
               add_result(KIND_BATCH, 8'h00, 1'b0, 64'd0,
                          cur_delete ? ST_BAD_DELETE : ST_BAD_PUT);
            end
            rearm_parser();
         end else if (byte_results.size() == 0) begin
            add_result(KIND_BATCH, 8'h00, 1'b0, 64'd0, ST_TOO_SHORT);
            rearm_parser();
         end
      end

      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last = 1'b1;
      end
      foreach (byte_results[i]) begin
         expected_results.insert(expected_results.size(), byte_results[i]);
      end
   endfunction

   // Follow register writes, predict each byte transaction, check each result transaction
   always @(posedge clock) begin : watch_channels
      parser_result_type want;
      if (reset) begin
         put_tag = 8'd1;
         del_tag = 8'd0;
         rearm_parser();
         expected_results.delete();
         mismatches   = 0;
         results_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VALUE_TAG) begin
               put_tag = csr_data;
            end else begin
               del_tag = csr_data;
            end
         end

         if (req_valid && req_ready) begin
            predict_byte(req_data_byte, req_batch_end);
         end

         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result with none expected: kind=%0d byte=%h del=%0d",
                           $realtime, rsp_kind, rsp_payload_byte, rsp_record_is_delete);
               end
            end else begin
               want = expected_results.pop_front();
               if (want.kind !== rsp_kind || want.payload_byte !== rsp_payload_byte ||
                   want.record_is_delete !== rsp_record_is_delete ||
                   want.sequence_res !== rsp_sequence_res ||
                   want.status !== rsp_status || want.last !== rsp_last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected kind=%0d byte=%h del=%0d seq=%h status=%0d last=%0d",
                              want.kind, want.payload_byte, want.record_is_delete,
                              want.sequence_res, want.status, want.last);
                     $display("   actual   kind=%0d byte=%h del=%0d seq=%h status=%0d last=%0d",
                              rsp_kind, rsp_payload_byte, rsp_record_is_delete,
                              rsp_sequence_res, rsp_status, rsp_last);
                  end
               end
            end
         end
      end

      mismatch_count  <= mismatches;
      pending_results <= expected_results.size();
      results_checked <= results_seen;
   end

endmodule

>>> test/tb_write_batch_record_parser.sv
// Testbench top for the write batch record parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_write_batch_record_parser import wbrp_pkg::*; ;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int CFG_PAUSE     = 4;
   localparam int PHASE_BYTES   = 72;

   logic clock;
   logic reset;

   wbrp_req_if req_ch();
   wbrp_rsp_if rsp_ch();
   wbrp_csr_if csr_ch();

   int mismatch_count;
   int pending_results;
   int results_checked;

   write_batch_record_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   wbrp_result_checker result_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_ch.valid),
      .req_ready            (req_ch.ready),
      .req_data_byte        (req_ch.data_byte),
      .req_batch_end        (req_ch.batch_end),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_kind             (rsp_ch.kind),
      .rsp_payload_byte     (rsp_ch.payload_byte),
      .rsp_record_is_delete (rsp_ch.record_is_delete),
      .rsp_sequence_res     (rsp_ch.sequence_res),
      .rsp_status           (rsp_ch.status),
      .rsp_last             (rsp_ch.last),
      .csr_valid            (csr_ch.valid),
      .csr_ready            (csr_ch.ready),
      .csr_index            (csr_ch.index),
      .csr_data             (csr_ch.data),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results),
      .results_checked      (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Tag codes currently loaded, used to build well-formed records
   logic [7:0]  cfg_put = 8'd1;
   logic [7:0]  cfg_del = 8'd0;
   logic [7:0]  batch_q[$];
   int          burst_left   = 0;
   int          bytes_sent   = 0;
   int          batches_sent = 0;
   int          tag_settings = 1;
   int          phase_end    = 0;

   // Receiver stall pattern: switches between randomly chosen stall modes
   int          stall_mode = 0;
   int          mode_left  = 0;
   int unsigned stall_tick = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      stall_tick++;
      unique case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= (stall_tick % 5) != 0;
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog: end the run if no transaction moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results still expected",
                  IDLE_LIMIT, pending_results);
         $display("tb_write_batch_record_parser: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Append one byte to the batch under construction
   function automatic void queue_byte(input logic [7:0] b);
      batch_q.insert(batch_q.size(), b);
   endfunction

   // Drive one byte, idling between bursts, and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic end_flag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.batch_end <= end_flag;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_batch();
      foreach (batch_q[i]) begin
         send_byte(batch_q[i], i == batch_q.size() - 1);
      end
      batches_sent++;
   endtask

   // Append a varint length: plain, padded with redundant bytes, or over-long
   task automatic push_length(input logic [31:0] len, input int style);
      logic [31:0] rest;
      int          nbytes;
      rest = len;
      if (style == 2) begin
         repeat (VARINT_MAX_BYTES) queue_byte({1'b1, 7'($urandom)});
      end else if (style == 1) begin
         nbytes = $urandom_range(2, VARINT_MAX_BYTES);
         for (int i = 0; i < nbytes - 1; i++) begin
            queue_byte({1'b1, len[7*i +: 7]});
         end
         // a fifth byte carries bits above bit 31 that must be dropped
         if (nbytes == VARINT_MAX_BYTES) begin
            queue_byte({1'b0, 3'($urandom), len[31:28]});
         end else begin
            queue_byte({1'b0, len[7*(nbytes-1) +: 7]});
         end
      end else begin
         do begin
            queue_byte({(rest > 32'd127), rest[6:0]});
            rest = rest >> 7;
         end while (rest != 0);
      end
   endtask

   task automatic push_string();
      int len;
      int style;
      len   = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 5);
      style = $urandom_range(0, 24);
      style = (style == 0) ? 2 : (style <= 3) ? 1 : 0;
      push_length(len, style);
      if (style != 2) begin
         repeat (len) queue_byte(8'($urandom));
      end
   endtask

   // Build one batch: mostly well-formed, with wrong counts, bad tags and truncation mixed in
   task automatic build_batch();
      logic [63:0] seq;
      logic [31:0] count;
      logic [7:0]  tag;
      int          nrec;
      int          pick;
      int          keep;
      batch_q.delete();
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 16)) queue_byte(8'($urandom));
         return;
      end
      case ($urandom_range(0, 3))
         0:       seq = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2);
         1:       seq = 64'($urandom_range(0, 255));
         default: seq = {$urandom, $urandom};
      endcase
      nrec = $urandom_range(0, 4);
      pick = $urandom_range(0, 9);
      count = (pick == 0) ? $urandom : (pick == 1) ? $urandom_range(0, 5) : nrec;
      for (int i = 0; i < SEQ_BYTES; i++) queue_byte(seq[8*i +: 8]);
      for (int i = 0; i < HEADER_BYTES - SEQ_BYTES; i++) queue_byte(count[8*i +: 8]);
      for (int r = 0; r < nrec; r++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            do tag = 8'($urandom); while (tag == cfg_put || tag == cfg_del);
            queue_byte(tag);
            continue;
         end
         queue_byte((pick < 11) ? cfg_put : cfg_del);
         push_string();
         if (pick < 11) begin
            push_string();
         end
      end
      // cut the batch short now and then
      if ($urandom_range(0, 6) == 0) begin
         keep = $urandom_range(1, batch_q.size());
         while (batch_q.size() > keep) void'(batch_q.pop_back());
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Load new tag codes once the parser has drained
   task automatic set_tags(input logic [7:0] put_code, input logic [7:0] del_code);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results != 0);
      repeat (CFG_PAUSE) @(posedge clock);
      write_reg(CSR_VALUE_TAG, put_code);
      write_reg(CSR_DELETION_TAG, del_code);
      csr_ch.valid <= 1'b0;
      cfg_put = put_code;
      cfg_del = del_code;
      tag_settings++;
   endtask

   // Send whole batches until the running byte budget of this phase is spent
   task automatic run_random_phase();
      phase_end = phase_end + PHASE_BYTES;
      do begin
         build_batch();
         send_batch();
      end while (bytes_sent < phase_end);
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.batch_end <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_VALUE_TAG;
      csr_ch.data      <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Header cut off at its first byte
      batch_q = '{8'h00};
      send_batch();

      // Maximal start sequence that wraps: a put with one key byte, then an empty delete
      batch_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h02, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h01, 8'hFF, 8'h00,
                  8'h00, 8'h00};
      send_batch();

      // Random batches under default, extreme, equal and random tag codes
      phase_end = bytes_sent;
      run_random_phase();
      set_tags(8'hFF, 8'h00);
      run_random_phase();
      set_tags(8'h00, 8'hFF);
      run_random_phase();
      set_tags(8'h5A, 8'h5A);
      run_random_phase();
      set_tags(8'($urandom), 8'($urandom));
      run_random_phase();

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d batches under %0d tag settings", bytes_sent,
               batches_sent, tag_settings);
      $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb_write_batch_record_parser: PASS");
      end else begin
         $display("tb_write_batch_record_parser: FAIL");
      end
      $finish;
   end

endmodule
